// ----- rtl/core/fwsm_pkg.sv -----
`default_nettype none
package fwsm_pkg;

    localparam int CNT_W          = 16;
    localparam int SPEED_W        = 16;
    localparam int PROD_W         = 2 * CNT_W;
    localparam int CFG_W          = 16;
    localparam int NUM_WHEELS_DEF = 4;

    localparam logic [CFG_W-1:0] NUMERATOR_RST   = 16'd1904;
    localparam logic [CFG_W-1:0] DENOMINATOR_RST = 16'd125;

    // configuration register indexes
    localparam logic CFG_NUMERATOR   = 1'b0;
    localparam logic CFG_DENOMINATOR = 1'b1;

    // input transaction kinds
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // one memory row per wheel
    typedef struct packed {
        logic             dir;
        logic [CNT_W-1:0] rev;
        logic [CNT_W-1:0] fwd;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EDGE_WR = 7'b0000010,
        S_TICK_LD = 7'b0000100,
        S_TICK_MUL = 7'b0001000,
        S_TICK_DIV = 7'b0010000,
        S_TICK_WAIT = 7'b0100000,
        S_TICK_OUT = 7'b1000000
    } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/fwsm_ram.sv -----
`default_nettype none
module fwsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/fwsm_div.sv -----
`default_nettype none
// 32/16 restoring divider, one quotient bit per cycle.
// A quotient that does not fit 16 bits (zero divisor included) gives all ones.
module fwsm_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [fwsm_pkg::PROD_W-1:0]   dividend,
    input  wire logic [fwsm_pkg::CNT_W-1:0]    divisor,
    output logic                               done,
    output logic      [fwsm_pkg::SPEED_W-1:0]  quotient
);
    import fwsm_pkg::*;

    localparam int STEP_W = $clog2(SPEED_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [SPEED_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   dvs_reg, dvs_next;
    logic [CNT_W:0]     trial;
    logic               fits;

    assign trial = {rem_reg, quo_reg[SPEED_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            dvs_next = divisor;
            cnt_next = '0;
            if (dividend[PROD_W-1:CNT_W] >= divisor)
            begin
                quo_next  = '1;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = dividend[PROD_W-1:CNT_W];
                quo_next  = dividend[CNT_W-1:0];
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? CNT_W'(trial - {1'b0, dvs_reg}) : trial[CNT_W-1:0];
            quo_next = {quo_reg[SPEED_W-2:0], fits};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(SPEED_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- rtl/core/four_wheel_encoder_speed_meter.sv -----
`default_nettype none
// Encoder pulse-count tachometer for NUM_WHEELS wheels. An input transaction with
// tuser = 0 is an encoder edge: tdata carries the wheel and the direction pin level;
// the level becomes the wheel's direction and the wheel's forward (level 1) or reverse
// (level 0) count goes up by one, wrapping at 16 bits. Edges for a wheel at or beyond
// NUM_WHEELS are dropped. An input transaction with tuser = 1 is a period tick: the
// block sends one output transaction per wheel in wheel order, tlast on the final one,
// with speed = max(fwd, rev) * speed_numerator / speed_denominator, truncated and
// saturated at 65535 (a zero denominator gives 65535), and clears all counts; the
// directions are kept. Counts and directions live in a one-row-per-wheel RAM with
// per-row valid flops, so reset takes effect at once with no clearing pass.
// One transaction at a time. An edge reads the wheel's row and writes it back with one
// count bumped. A tick takes the wheels in turn: read the row and clear its counts, multiply,
// divide bit-serially, then load the output register once it is free of backpressure.
// A new input transaction is taken as soon as the last result is in the output
// register. Write the configuration only while the block is idle.
module four_wheel_encoder_speed_meter #(
    parameter int NUM_WHEELS = fwsm_pkg::NUM_WHEELS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration write port
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [fwsm_pkg::CFG_W-1:0]  cfg_wdata,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [1:0] wheel, [2] dir_level
    input  wire logic                        s_tuser,   // [0] operation
    // output stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [23:0]                 m_tdata,   // [1:0] wheel_index, [17:2] speed,
                                                        // [18] direction
    output logic                             m_tlast
);
    import fwsm_pkg::*;

    localparam int AW = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic                    lvl_reg, lvl_next;
    logic [NUM_WHEELS-1:0]   valid_reg, valid_next;
    logic [CFG_W-1:0]        num_reg, den_reg;

    // payload
    logic [CNT_W-1:0]        big_reg, big_next;
    logic                    dir_reg, dir_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              out_wheel_reg, out_wheel_next;
    logic [SPEED_W-1:0]      out_speed_reg, out_speed_next;
    logic                    out_dir_reg, out_dir_next;
    logic                    out_last_reg, out_last_next;

    // memory and divider hookup
    logic                    ram_we;
    row_t                    ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [ROW_W-1:0]        ram_rdata;
    row_t                    cur_row;
    logic                    div_start;
    logic                    div_done;
    logic [SPEED_W-1:0]      div_quot;

    logic                    is_last;
    logic                    out_free;
    logic [AW-1:0]           in_addr;

    fwsm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_WHEELS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fwsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // rows never written since reset read as zero
    assign cur_row  = valid_reg[addr_reg] ? row_t'(ram_rdata) : '0;
    assign is_last  = addr_reg == AW'(NUM_WHEELS - 1);
    assign out_free = !out_valid_reg || m_tready;
    assign in_addr  = (s_tuser == OP_TICK) ? '0 : AW'(s_tdata[1:0]);
    assign s_tready = state_reg == S_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        lvl_next       = lvl_reg;
        valid_next     = valid_reg;
        big_next       = big_reg;
        dir_next       = dir_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_wheel_next = out_wheel_reg;
        out_speed_next = out_speed_reg;
        out_dir_next   = out_dir_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_wdata      = cur_row;
        ram_raddr      = addr_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = in_addr;
                if (s_tvalid)
                begin
                    addr_next = in_addr;
                    lvl_next  = s_tdata[2];
                    if (s_tuser == OP_TICK)
                    begin
                        state_next = S_TICK_LD;
                    end
                    else if (32'(s_tdata[1:0]) < NUM_WHEELS)
                    begin
                        state_next = S_EDGE_WR;
                    end
                end
            end
            S_EDGE_WR:
            begin
                // read data arrived, bump one count and write back
                ram_we        = 1'b1;
                ram_wdata.dir = lvl_reg;
                if (lvl_reg)
                begin
                    ram_wdata.fwd = cur_row.fwd + CNT_W'(1);
                end
                else
                begin
                    ram_wdata.rev = cur_row.rev + CNT_W'(1);
                end
                valid_next[addr_reg] = 1'b1;
                state_next           = S_IDLE;
            end
            S_TICK_LD:
            begin
                big_next      = (cur_row.fwd > cur_row.rev) ? cur_row.fwd : cur_row.rev;
                dir_next      = cur_row.dir;
                // clear counts, keep direction
                ram_we        = 1'b1;
                ram_wdata.fwd = '0;
                ram_wdata.rev = '0;
                valid_next[addr_reg] = 1'b1;
                state_next    = S_TICK_MUL;
            end
            S_TICK_MUL:
            begin
                prod_next  = PROD_W'(big_reg) * PROD_W'(num_reg);
                state_next = S_TICK_DIV;
            end
            S_TICK_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_TICK_WAIT;
            end
            S_TICK_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_TICK_OUT;
                end
            end
            S_TICK_OUT:
            begin
                ram_raddr = addr_reg + AW'(1);
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_wheel_next = 2'(addr_reg);
                    out_speed_next = div_quot;
                    out_dir_next   = dir_reg;
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg + AW'(1);
                        state_next = S_TICK_LD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            addr_reg      <= '0;
            lvl_reg       <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            lvl_reg       <= lvl_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= NUMERATOR_RST;
            den_reg <= DENOMINATOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUMERATOR:   num_reg <= cfg_wdata;
                CFG_DENOMINATOR: den_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        big_reg       <= big_next;
        dir_reg       <= dir_next;
        prod_reg      <= prod_next;
        out_wheel_reg <= out_wheel_next;
        out_speed_reg <= out_speed_next;
        out_dir_reg   <= out_dir_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_dir_reg, out_speed_reg, out_wheel_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire
